// ===== src/ordered_key_value_table_unit_defines.svh =====
`ifndef ORDERED_KEY_VALUE_TABLE_UNIT_DEFINES_SVH
`define ORDERED_KEY_VALUE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define KVT_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define KVT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/kvt_pkg.sv =====
`timescale 1ns / 1ps

package kvt_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	localparam int CMD_BITS    = 3;
	localparam int POS_BITS    = 4;
	localparam int STATUS_BITS = 2;
	localparam int COUNT_BITS  = 5;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_INSERT   = 3'd0,
		CMD_UPDATE   = 3'd1,
		CMD_UPSERT   = 3'd2,
		CMD_ERASE    = 3'd3,
		CMD_LOOKUP   = 3'd4,
		CMD_READ_POS = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK      = 2'd0,
		ST_REFUSED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	// Broadcast to every cell of the row.
	typedef struct packed {
		logic capture;
		logic append;
		logic update;
		logic erase;
	} cell_ctl_t;

endpackage

// ===== src/kvt_if.sv =====
`timescale 1ns / 1ps

interface kvt_req_if import kvt_pkg::*; #(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
	logic                  valid;
	logic                  ready;
	logic [CMD_BITS-1:0]   command;
	logic [KEY_BITS-1:0]   key;
	logic [VALUE_BITS-1:0] value;
	logic [POS_BITS-1:0]   position;

	modport source (output valid, command, key, value, position, input ready);
	modport sink (input valid, command, key, value, position, output ready);
endinterface

interface kvt_rsp_if import kvt_pkg::*; #(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
	logic                   valid;
	logic                   ready;
	logic [STATUS_BITS-1:0] status;
	logic [KEY_BITS-1:0]    found_key;
	logic [VALUE_BITS-1:0]  found_value;
	logic [COUNT_BITS-1:0]  entry_count;

	modport source (output valid, status, found_key, found_value, entry_count, input ready);
	modport sink (input valid, status, found_key, found_value, entry_count, output ready);
endinterface

// ===== src/kvt_cell.sv =====
`timescale 1ns / 1ps

module kvt_cell import kvt_pkg::*; #(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int CNT_W      = COUNT_BITS,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic [CNT_W-1:0]      count,
	input  logic [KEY_BITS-1:0]   probe_key,
	input  logic [KEY_BITS-1:0]   new_key,
	input  logic [VALUE_BITS-1:0] new_value,
	input  logic [POS_BITS-1:0]   position,
	input  logic [KEY_BITS-1:0]   next_key,
	input  logic [VALUE_BITS-1:0] next_value,
	input  logic                  shift_in,
	output logic                  shift_out,
	output logic                  hit,
	output logic                  pos_sel,
	output logic [KEY_BITS-1:0]   key,
	output logic [VALUE_BITS-1:0] value
);

	localparam bit POS_REACH = (IDX < (1 << POS_BITS));

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  hit_s1;
	logic                  live;
	logic                  tail;

	assign live = CNT_W'(IDX) < count;
	assign tail = CNT_W'(IDX) == count;

	// every cell from the matching one upwards pulls its upper neighbour down
	assign shift_out = shift_in | hit_s1;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			hit_s1 <= live && (key_q == probe_key);
		end
		if (ctl.erase && shift_out) begin
			key_q   <= next_key;
			value_q <= next_value;
		end else if (ctl.append && tail) begin
			key_q   <= new_key;
			value_q <= new_value;
		end else if (ctl.update && hit_s1) begin
			value_q <= new_value;
		end
	end

	assign hit     = hit_s1;
	assign pos_sel = POS_REACH && live && (position == POS_BITS'(IDX));
	assign key     = key_q;
	assign value   = value_q;

endmodule

// ===== src/ordered_key_value_table_unit.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Beat contents
// req     | in  | command, key, value, position
// rsp     | out | status, found_key, found_value, entry_count
//
// Each command runs as a key compare in every cell, registered at the accepting edge,
// then hit reduction, decision and cell write, registered at the commit edge.
// One command in flight; a new beat is taken while a result waits in the output register.
// A waiting result stalls the commit of the next command until rsp is taken.
// arst_n clears the entry count, busy flag and output valid; entries need no clearing.
`include "ordered_key_value_table_unit_defines.svh"

module ordered_key_value_table_unit import kvt_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	kvt_req_if.sink   req,
	kvt_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                  busy_q;
	logic [CMD_BITS-1:0]   cmd_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic [POS_BITS-1:0]   pos_s1;
	logic [CNT_W-1:0]      count_q;

	logic                   rsp_valid_q;
	logic [STATUS_BITS-1:0] status_q;
	logic [KEY_BITS-1:0]    found_key_q;
	logic [VALUE_BITS-1:0]  found_value_q;
	logic [COUNT_BITS-1:0]  entry_count_q;

	logic      accept;
	logic      commit;
	cell_ctl_t ctl;

	logic [CAPACITY-1:0]   hit_w;
	logic [CAPACITY-1:0]   pos_w;
	logic [CAPACITY:0]     shift_w;
	logic [KEY_BITS-1:0]   key_w   [CAPACITY+1];
	logic [VALUE_BITS-1:0] value_w [CAPACITY+1];

	logic                  any_hit;
	logic                  pos_ok;
	logic                  full;
	logic [VALUE_BITS-1:0] hit_value;
	logic [KEY_BITS-1:0]   pos_key;
	logic [VALUE_BITS-1:0] pos_value;

	status_t               nxt_status;
	logic [KEY_BITS-1:0]   nxt_key;
	logic [VALUE_BITS-1:0] nxt_value;
	logic [CNT_W-1:0]      nxt_count;
	logic                  do_append;
	logic                  do_update;
	logic                  do_erase;

	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;
	assign commit    = busy_q && (!rsp_valid_q || rsp.ready);

	assign ctl.capture = accept;
	assign ctl.append  = commit && do_append;
	assign ctl.update  = commit && do_update;
	assign ctl.erase   = commit && do_erase;

	assign shift_w[0]        = 1'b0;
	assign key_w[CAPACITY]   = '0;
	assign value_w[CAPACITY] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		kvt_cell #(
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS),
			.CNT_W      (CNT_W),
			.IDX        (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.probe_key  (req.key),
			.new_key    (key_s1),
			.new_value  (value_s1),
			.position   (pos_s1),
			.next_key   (key_w[i+1]),
			.next_value (value_w[i+1]),
			.shift_in   (shift_w[i]),
			.shift_out  (shift_w[i+1]),
			.hit        (hit_w[i]),
			.pos_sel    (pos_w[i]),
			.key        (key_w[i]),
			.value      (value_w[i])
		);
	end

	// hits are one-hot at most (keys unique), so AND-OR selection
	always_comb begin
		hit_value = '0;
		pos_key   = '0;
		pos_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (hit_w[i]) begin
				hit_value = hit_value | value_w[i];
			end
			if (pos_w[i]) begin
				pos_key   = pos_key | key_w[i];
				pos_value = pos_value | value_w[i];
			end
		end
	end

	assign any_hit = |hit_w;
	assign pos_ok  = |pos_w;
	assign full    = count_q == CNT_W'(CAPACITY);

	always_comb begin
		nxt_status = ST_REFUSED;
		nxt_key    = key_s1;
		nxt_value  = '0;
		do_append  = 1'b0;
		do_update  = 1'b0;
		do_erase   = 1'b0;
		unique case (cmd_s1) inside
			CMD_INSERT, CMD_UPSERT: begin
				if (any_hit) begin
					if (cmd_s1 == CMD_UPSERT) begin
						nxt_status = ST_OK;
						nxt_value  = value_s1;
						do_update  = 1'b1;
					end
				end else if (full) begin
					nxt_status = ST_FULL;
				end else begin
					nxt_status = ST_OK;
					nxt_value  = value_s1;
					do_append  = 1'b1;
				end
			end
			CMD_UPDATE: begin
				if (any_hit) begin
					nxt_status = ST_OK;
					nxt_value  = value_s1;
					do_update  = 1'b1;
				end
			end
			CMD_ERASE: begin
				if (any_hit) begin
					nxt_status = ST_OK;
					nxt_value  = hit_value;
					do_erase   = 1'b1;
				end
			end
			CMD_LOOKUP: begin
				if (any_hit) begin
					nxt_status = ST_OK;
					nxt_value  = hit_value;
				end
			end
			CMD_READ_POS: begin
				if (pos_ok) begin
					nxt_status = ST_OK;
					nxt_key    = pos_key;
					nxt_value  = pos_value;
				end
			end
			default: begin
				nxt_status = ST_REFUSED;
			end
		endcase
	end

	always_comb begin
		nxt_count = count_q;
		if (do_append) begin
			nxt_count = count_q + 1'b1;
		end else if (do_erase) begin
			nxt_count = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				count_q     <= nxt_count;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= req.command;
			key_s1   <= req.key;
			value_s1 <= req.value;
			pos_s1   <= req.position;
		end
		if (commit) begin
			status_q      <= nxt_status;
			found_key_q   <= nxt_key;
			found_value_q <= nxt_value;
			entry_count_q <= COUNT_BITS'(nxt_count);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.found_key   = found_key_q;
	assign rsp.found_value = found_value_q;
	assign rsp.entry_count = entry_count_q;

	`KVT_ASSERT_IMPLY(a_hit_onehot, busy_q, $onehot0(hit_w), "more than one cell matched the key")
	`KVT_ASSERT_IMPLY(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "entry count beyond capacity")
	`KVT_ASSERT_IMPLY(a_append_room, ctl.append, !full, "append into a full table")
	`KVT_ASSERT_NEXT(a_erase_count, ctl.erase, count_q == $past(count_q) - 1'b1,
		"erase did not drop the entry count by one")

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import kvt_pkg::*;

	localparam int TABLE_DEPTH = CAPACITY_DEF;
	localparam int KW          = KEY_BITS_DEF;
	localparam int VW          = VALUE_BITS_DEF;
	localparam int POOL_SIZE   = 24;
	localparam int IDLE_PCT    = 23;

	// command codes with no operation behind them
	localparam logic [CMD_BITS-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_BITS-1:0] CMD_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [STATUS_BITS-1:0] status;
		logic [KW-1:0]          found_key;
		logic [VW-1:0]          found_value;
		logic [COUNT_BITS-1:0]  entry_count;
	} table_answer_t;

	logic clk;
	logic arst_n;

	kvt_req_if req_bus ();
	kvt_rsp_if rsp_bus ();

	ordered_key_value_table_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// shadow copy of the table
	logic [KW-1:0] shadow_keys [TABLE_DEPTH];
	logic [VW-1:0] shadow_vals [TABLE_DEPTH];
	int            shadow_count;

	table_answer_t expected_answers [$];
	logic [KW-1:0] key_pool [POOL_SIZE];
	int            mismatch_count;
	bit            src_gaps;
	bit            sink_gaps;
	int            hold_left;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		#2_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// Applies one command to the shadow table and returns the answer it gives.
	function automatic table_answer_t table_apply(input logic [CMD_BITS-1:0] cmd,
			input logic [KW-1:0] key, input logic [VW-1:0] value,
			input logic [POS_BITS-1:0] pos);
		table_answer_t ans;
		int hit;
		hit = -1;
		for (int i = 0; i < shadow_count; i++)
			if (hit < 0 && shadow_keys[i] == key)
				hit = i;
		ans.status      = ST_REFUSED;
		ans.found_key   = key;
		ans.found_value = '0;
		case (cmd)
		CMD_INSERT, CMD_UPDATE, CMD_UPSERT: begin
			if (hit >= 0) begin
				if (cmd != CMD_INSERT) begin
					shadow_vals[hit] = value;
					ans.status      = ST_OK;
					ans.found_value = value;
				end
			end else if (cmd != CMD_UPDATE) begin
				// duplicate check wins over full, hence only here
				if (shadow_count >= TABLE_DEPTH) begin
					ans.status = ST_FULL;
				end else begin
					shadow_keys[shadow_count] = key;
					shadow_vals[shadow_count] = value;
					shadow_count++;
					ans.status      = ST_OK;
					ans.found_value = value;
				end
			end
		end
		CMD_ERASE: begin
			if (hit >= 0) begin
				ans.found_value = shadow_vals[hit];
				for (int i = hit; i + 1 < shadow_count; i++) begin
					shadow_keys[i] = shadow_keys[i + 1];
					shadow_vals[i] = shadow_vals[i + 1];
				end
				shadow_count--;
				ans.status = ST_OK;
			end
		end
		CMD_LOOKUP: begin
			if (hit >= 0) begin
				ans.found_value = shadow_vals[hit];
				ans.status      = ST_OK;
			end
		end
		CMD_READ_POS: begin
			if (int'(pos) < shadow_count) begin
				ans.found_key   = shadow_keys[pos];
				ans.found_value = shadow_vals[pos];
				ans.status      = ST_OK;
			end
		end
		default: ;
		endcase
		ans.entry_count = COUNT_BITS'(shadow_count);
		return ans;
	endfunction

	// Offers one beat, waits for it to be taken, then records the answer due.
	task automatic issue_command(input logic [CMD_BITS-1:0] cmd, input logic [KW-1:0] key,
			input logic [VW-1:0] value, input logic [POS_BITS-1:0] pos);
		while (src_gaps && $urandom_range(99) < IDLE_PCT) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid    <= 1'b1;
		req_bus.command  <= cmd;
		req_bus.key      <= key;
		req_bus.value    <= value;
		req_bus.position <= pos;
		do
			@(posedge clk);
		while (!req_bus.ready);
		expected_answers.push_back(table_apply(cmd, key, value, pos));
	endtask

	task automatic wait_for_answers();
		req_bus.valid <= 1'b0;
		while (expected_answers.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [KW-1:0] pick_key();
		if ($urandom_range(99) < 85)
			return key_pool[$urandom_range(POOL_SIZE - 1)];
		return $urandom;
	endfunction

	function automatic logic [CMD_BITS-1:0] pick_cmd(input int erase_pct);
		int roll;
		roll = $urandom_range(99);
		if (roll < 3)
			return ($urandom_range(1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
		if (roll < 3 + erase_pct)
			return CMD_ERASE;
		case ($urandom_range(5))
		0, 1: return CMD_INSERT;
		2: return CMD_UPDATE;
		3: return CMD_UPSERT;
		4: return CMD_LOOKUP;
		default: return CMD_READ_POS;
		endcase
	endfunction

	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_bus.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (sink_gaps) begin
			rsp_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
		end else begin
			rsp_bus.ready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		table_answer_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (expected_answers.size() == 0) begin
				$display("%0t: result beat with none expected, expected none, actual %h/%h/%h/%h",
					$time, rsp_bus.status, rsp_bus.found_key, rsp_bus.found_value,
					rsp_bus.entry_count);
				mismatch_count++;
			end else begin
				want = expected_answers.pop_front();
				check_field("status", 32'(want.status), 32'(rsp_bus.status));
				check_field("found_key", 32'(want.found_key), 32'(rsp_bus.found_key));
				check_field("found_value", 32'(want.found_value), 32'(rsp_bus.found_value));
				check_field("entry_count", 32'(want.entry_count), 32'(rsp_bus.entry_count));
			end
		end
	end

	// every operation, unknown codes and the refusal cases on a near-empty table
	task automatic test_basic_commands();
		issue_command(CMD_LOOKUP, 32'h1234_5678, 32'h0, 4'd0);
		issue_command(CMD_READ_POS, 32'h0000_00AA, 32'h0, 4'd0);
		issue_command(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 4'd0);
		issue_command(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 4'd15);
		issue_command(CMD_INSERT, 32'h0000_0000, 32'h5555_5555, 4'd0);
		issue_command(CMD_UPDATE, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 4'd0);
		issue_command(CMD_UPDATE, 32'h8000_0001, 32'h1111_1111, 4'd0);
		issue_command(CMD_UPSERT, 32'h8000_0001, 32'h2222_2222, 4'd0);
		issue_command(CMD_UPSERT, 32'h8000_0001, 32'h3333_3333, 4'd0);
		issue_command(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 4'd0);
		issue_command(CMD_ERASE, 32'h0000_0000, 32'h0, 4'd0);
		issue_command(CMD_ERASE, 32'h0000_0000, 32'h0, 4'd0);
		issue_command(CMD_READ_POS, 32'h0, 32'h0, 4'd1);
		issue_command(CMD_READ_POS, 32'hDEAD_BEEF, 32'h0, 4'd15);
		issue_command(CMD_SPARE_LO, 32'hFFFF_FFFF, 32'h9999_9999, 4'd0);
		issue_command(CMD_SPARE_HI, 32'hFFFF_FFFF, 32'h7777_7777, 4'd15);
	endtask

	// fill to capacity, then refusals at full, last slot and close-up after erase
	task automatic test_full_table();
		int n;
		n = 0;
		while (shadow_count < TABLE_DEPTH) begin
			issue_command(CMD_INSERT, {16'hA5C3, 16'(n)}, $urandom, 4'($urandom));
			n++;
		end
		issue_command(CMD_INSERT, 32'h0BAD_0001, 32'h1, 4'd0);
		issue_command(CMD_UPSERT, 32'h0BAD_0002, 32'h2, 4'd0);
		issue_command(CMD_INSERT, 32'hFFFF_FFFF, 32'h3, 4'd0);
		issue_command(CMD_UPDATE, 32'hFFFF_FFFF, 32'h4, 4'd0);
		issue_command(CMD_READ_POS, 32'h0, 32'h0, 4'd15);
		issue_command(CMD_ERASE, shadow_keys[0], 32'h0, 4'd0);
		issue_command(CMD_READ_POS, 32'h0, 32'h0, 4'd0);
	endtask

	// swings between insert-heavy and erase-heavy spells to cross full and empty
	task automatic test_random_mix(input int beats);
		int erase_pct;
		erase_pct = 8;
		for (int i = 0; i < beats; i++) begin
			if (i % 60 == 59)
				erase_pct = (erase_pct == 8) ? 38 : 8;
			issue_command(pick_cmd(erase_pct), pick_key(), $urandom, 4'($urandom));
		end
	endtask

	task automatic test_back_to_back();
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		test_random_mix(300);
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
	endtask

	// output held off while the sender keeps offering, so the input must stall
	task automatic test_output_stall();
		src_gaps  = 1'b0;
		hold_left = 80;
		test_random_mix(24);
		wait_for_answers();
		src_gaps = 1'b1;
	endtask

	initial begin
		arst_n           = 1'b0;
		req_bus.valid    = 1'b0;
		req_bus.command  = '0;
		req_bus.key      = '0;
		req_bus.value    = '0;
		req_bus.position = '0;
		rsp_bus.ready    = 1'b0;
		mismatch_count   = 0;
		shadow_count     = 0;
		hold_left        = 0;
		src_gaps         = 1'b1;
		sink_gaps        = 1'b1;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			shadow_keys[i] = '0;
			shadow_vals[i] = '0;
		end
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_commands();
		test_full_table();
		test_random_mix(500);
		test_output_stall();
		test_back_to_back();
		wait_for_answers();
		test_random_mix(500);

		wait_for_answers();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

// ===== ordered_key_value_table_unit.f =====
+incdir+src
src/kvt_pkg.sv
src/kvt_if.sv
src/kvt_cell.sv
src/ordered_key_value_table_unit.sv
tb/tb_top.sv
